// ===== src/kcm_pkg.sv =====
`timescale 1ns / 1ps

package kcm_pkg;

   localparam int MAX_VERTICES = 256;
   localparam int V_W = 9;
   localparam int ADDR_W = $clog2(MAX_VERTICES);
   localparam int DATA_W = 9;
   localparam int CNT_W = 8;
   localparam int WEIGHT_W = 32;

   typedef struct packed {
      logic [V_W-1:0]             vertex_a;
      logic [V_W-1:0]             vertex_b;
      logic signed [WEIGHT_W-1:0] edge_weight;
   } req_type;

   typedef struct packed {
      logic                       accepted;
      logic [V_W-1:0]             out_vertex_a;
      logic [V_W-1:0]             out_vertex_b;
      logic signed [WEIGHT_W-1:0] out_weight;
      logic [CNT_W-1:0]           tree_edges;
      logic                       tree_done;
      logic                       range_error;
   } rsp_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [DATA_W-1:0] wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_port_type;

   // written values below two act as two, above the store depth as the depth
   function automatic logic [V_W-1:0] clamp_count(input logic [V_W-1:0] value);
      logic [V_W-1:0] result;
      result = value;
      if (value < V_W'(2)) begin
         result = V_W'(2);
      end else if (value > V_W'(MAX_VERTICES)) begin
         result = V_W'(MAX_VERTICES);
      end
      return result;
   endfunction

endpackage

// ===== src/kruskal_component_merge.sv =====
`timescale 1ns / 1ps

// Judges edges for a Kruskal spanning tree, edges presented in nondecreasing
// weight order. Each edge not cut off by a csr write gives exactly one result,
// a one-cycle rsp_valid strobe that the receiver cannot hold off. Rejected
// edges (bad endpoint, self-loop, tree complete) give their result the cycle
// after the transfer; an edge inside one component is rejected from S_CHK once
// both endpoint labels are read. An edge that adds an unassigned vertex passes
// S_LDB, S_CHK and then S_LBL2 or S_SZINC; one that joins two components walks
// the label RAM's single read port to relabel the smaller component. busy is
// high while an edge is at work. After reset and after every csr write the
// label and size RAMs are swept to zero, which keeps busy high through the sweep.
module kruskal_component_merge (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  kcm_pkg::req_type        req_payload,
   output logic                    rsp_valid,
   output kcm_pkg::rsp_type        rsp_payload,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [kcm_pkg::V_W-1:0] csr_data
);

   logic [kcm_pkg::V_W-1:0]    vcount_ff, vcount_in;
   logic                       csr_write;
   kcm_pkg::mem_port_type      lbl_port, size_port;
   logic [kcm_pkg::DATA_W-1:0] lbl_rd, size_rd;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign vcount_in = csr_write ? kcm_pkg::clamp_count(csr_data) : vcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= kcm_pkg::V_W'(kcm_pkg::MAX_VERTICES);
      end else begin
         vcount_ff <= vcount_in;
      end
   end

   kcm_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .clear_req    (csr_write),
      .vertex_count (vcount_ff),
      .start        (start),
      .busy         (busy),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_payload  (rsp_payload),
      .lbl_port     (lbl_port),
      .lbl_rd       (lbl_rd),
      .size_port    (size_port),
      .size_rd      (size_rd)
   );

   kcm_ram #(
      .WIDTH  (kcm_pkg::DATA_W),
      .DEPTH  (kcm_pkg::MAX_VERTICES),
      .ADDR_W (kcm_pkg::ADDR_W)
   ) u_label_ram (
      .clock (clock),
      .we    (lbl_port.we),
      .waddr (lbl_port.waddr),
      .wdata (lbl_port.wdata),
      .raddr (lbl_port.raddr),
      .rdata (lbl_rd)
   );

   kcm_ram #(
      .WIDTH  (kcm_pkg::DATA_W),
      .DEPTH  (kcm_pkg::MAX_VERTICES),
      .ADDR_W (kcm_pkg::ADDR_W)
   ) u_size_ram (
      .clock (clock),
      .we    (size_port.we),
      .waddr (size_port.waddr),
      .wdata (size_port.wdata),
      .raddr (size_port.raddr),
      .rdata (size_rd)
   );

endmodule

// ===== src/kcm_ram.sv =====
`timescale 1ns / 1ps

module kcm_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/kcm_ctrl.sv =====
`timescale 1ns / 1ps

module kcm_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear_req,
   input  logic [kcm_pkg::V_W-1:0]     vertex_count,
   input  logic                        start,
   output logic                        busy,
   input  kcm_pkg::req_type            req_payload,
   output logic                        rsp_valid,
   output kcm_pkg::rsp_type            rsp_payload,
   output kcm_pkg::mem_port_type       lbl_port,
   input  logic [kcm_pkg::DATA_W-1:0]  lbl_rd,
   output kcm_pkg::mem_port_type       size_port,
   input  logic [kcm_pkg::DATA_W-1:0]  size_rd
);

   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_CLEAR = 12'b000000000010,
      S_LDB   = 12'b000000000100,
      S_CHK   = 12'b000000001000,
      S_LBL2  = 12'b000000010000,
      S_SZINC = 12'b000000100000,
      S_SZB   = 12'b000001000000,
      S_CMP   = 12'b000010000000,
      S_WALK  = 12'b000100000000,
      S_DRAIN = 12'b001000000000,
      S_SZW1  = 12'b010000000000,
      S_SZW2  = 12'b100000000000
   } state_type;

   state_type                      state_ff, state_in;
   kcm_pkg::req_type               req_ff, req_in;
   kcm_pkg::rsp_type               rsp_ff, rsp_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [kcm_pkg::DATA_W-1:0]     la_ff, la_in;
   logic [kcm_pkg::DATA_W-1:0]     lb_ff, lb_in;
   logic [kcm_pkg::DATA_W-1:0]     sa_ff, sa_in;
   logic [kcm_pkg::DATA_W-1:0]     from_ff, from_in;
   logic [kcm_pkg::DATA_W-1:0]     to_ff, to_in;
   logic [kcm_pkg::DATA_W-1:0]     sum_ff, sum_in;
   logic [kcm_pkg::V_W-1:0]        k_ff, k_in;
   logic                           pend_ff, pend_in;
   logic [kcm_pkg::ADDR_W-1:0]     paddr_ff, paddr_in;
   logic [kcm_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [kcm_pkg::ADDR_W-1:0]     clr_ff, clr_in;

   logic [kcm_pkg::V_W-1:0]        need;
   logic                           full;
   logic                           in_err;
   logic [kcm_pkg::V_W-1:0]        a_m1_in, a_m1, b_m1;
   logic [kcm_pkg::DATA_W-1:0]     lb_m1, la_m1, to_m1, from_m1, lbr_m1;
   logic [kcm_pkg::CNT_W-1:0]      count_inc;
   // shared adder: size increment and merged size
   logic [kcm_pkg::DATA_W-1:0]     add_x, add_y, add_sum;

   function automatic kcm_pkg::rsp_type make_rsp(
      input kcm_pkg::req_type         req,
      input logic                     acc,
      input logic                     err,
      input logic [kcm_pkg::CNT_W-1:0] cnt,
      input logic [kcm_pkg::V_W-1:0]  need_cnt
   );
      kcm_pkg::rsp_type r;
      r.accepted     = acc;
      r.out_vertex_a = req.vertex_a;
      r.out_vertex_b = req.vertex_b;
      r.out_weight   = req.edge_weight;
      r.tree_edges   = cnt;
      r.tree_done    = {1'b0, cnt} >= need_cnt;
      r.range_error  = err;
      return r;
   endfunction

   assign need      = vertex_count - kcm_pkg::V_W'(1);
   assign full      = {1'b0, count_ff} >= need;
   assign in_err    = (req_payload.vertex_a == '0) || (req_payload.vertex_b == '0) ||
                      (req_payload.vertex_a > vertex_count) ||
                      (req_payload.vertex_b > vertex_count);
   assign a_m1_in   = req_payload.vertex_a - kcm_pkg::V_W'(1);
   assign a_m1      = req_ff.vertex_a - kcm_pkg::V_W'(1);
   assign b_m1      = req_ff.vertex_b - kcm_pkg::V_W'(1);
   assign la_m1     = la_ff - kcm_pkg::DATA_W'(1);
   assign lb_m1     = lbl_rd - kcm_pkg::DATA_W'(1);
   assign lbr_m1    = lb_ff - kcm_pkg::DATA_W'(1);
   assign to_m1     = to_ff - kcm_pkg::DATA_W'(1);
   assign from_m1   = from_ff - kcm_pkg::DATA_W'(1);
   assign count_inc = count_ff + kcm_pkg::CNT_W'(1);
   assign add_sum   = add_x + add_y;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      la_in        = la_ff;
      lb_in        = lb_ff;
      sa_in        = sa_ff;
      from_in      = from_ff;
      to_in        = to_ff;
      sum_in       = sum_ff;
      k_in         = k_ff;
      pend_in      = pend_ff;
      paddr_in     = paddr_ff;
      count_in     = count_ff;
      clr_in       = clr_ff;
      add_x        = size_rd;
      add_y        = kcm_pkg::DATA_W'(1);
      lbl_port     = '0;
      size_port    = '0;

      case (state_ff)
         S_CLEAR: begin
            lbl_port.we     = 1'b1;
            lbl_port.waddr  = clr_ff;
            size_port.we    = 1'b1;
            size_port.waddr = clr_ff;
            clr_in          = clr_ff + kcm_pkg::ADDR_W'(1);
            if (clr_ff == kcm_pkg::ADDR_W'(kcm_pkg::MAX_VERTICES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            lbl_port.raddr = a_m1_in[kcm_pkg::ADDR_W-1:0];
            if (start) begin
               req_in = req_payload;
               if (in_err || (req_payload.vertex_a == req_payload.vertex_b) || full) begin
                  rsp_in       = make_rsp(req_payload, 1'b0, in_err, count_ff, need);
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = S_LDB;
               end
            end
         end
         S_LDB: begin
            lbl_port.raddr = b_m1[kcm_pkg::ADDR_W-1:0];
            la_in          = lbl_rd;
            state_in       = S_CHK;
         end
         S_CHK: begin
            if ((la_ff == '0) && (lbl_rd == '0)) begin
               lbl_port.we     = 1'b1;
               lbl_port.waddr  = a_m1[kcm_pkg::ADDR_W-1:0];
               lbl_port.wdata  = req_ff.vertex_a;
               size_port.we    = 1'b1;
               size_port.waddr = a_m1[kcm_pkg::ADDR_W-1:0];
               size_port.wdata = kcm_pkg::DATA_W'(2);
               state_in        = S_LBL2;
            end else if (la_ff == '0) begin
               lbl_port.we     = 1'b1;
               lbl_port.waddr  = a_m1[kcm_pkg::ADDR_W-1:0];
               lbl_port.wdata  = lbl_rd;
               size_port.raddr = lb_m1[kcm_pkg::ADDR_W-1:0];
               to_in           = lbl_rd;
               state_in        = S_SZINC;
            end else if (lbl_rd == '0) begin
               lbl_port.we     = 1'b1;
               lbl_port.waddr  = b_m1[kcm_pkg::ADDR_W-1:0];
               lbl_port.wdata  = la_ff;
               size_port.raddr = la_m1[kcm_pkg::ADDR_W-1:0];
               to_in           = la_ff;
               state_in        = S_SZINC;
            end else if (la_ff == lbl_rd) begin
               rsp_in       = make_rsp(req_ff, 1'b0, 1'b0, count_ff, need);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               size_port.raddr = la_m1[kcm_pkg::ADDR_W-1:0];
               lb_in           = lbl_rd;
               state_in        = S_SZB;
            end
         end
         S_LBL2: begin
            lbl_port.we    = 1'b1;
            lbl_port.waddr = b_m1[kcm_pkg::ADDR_W-1:0];
            lbl_port.wdata = req_ff.vertex_a;
            count_in       = count_inc;
            rsp_in         = make_rsp(req_ff, 1'b1, 1'b0, count_inc, need);
            rsp_valid_in   = 1'b1;
            state_in       = S_IDLE;
         end
         S_SZINC: begin
            size_port.we    = 1'b1;
            size_port.waddr = to_m1[kcm_pkg::ADDR_W-1:0];
            size_port.wdata = add_sum;
            count_in        = count_inc;
            rsp_in          = make_rsp(req_ff, 1'b1, 1'b0, count_inc, need);
            rsp_valid_in    = 1'b1;
            state_in        = S_IDLE;
         end
         S_SZB: begin
            sa_in           = size_rd;
            size_port.raddr = lbr_m1[kcm_pkg::ADDR_W-1:0];
            state_in        = S_CMP;
         end
         S_CMP: begin
            // on equal sizes vertex_a's component moves into vertex_b's
            if (sa_ff <= size_rd) begin
               from_in = la_ff;
               to_in   = lb_ff;
            end else begin
               from_in = lb_ff;
               to_in   = la_ff;
            end
            add_x    = sa_ff;
            add_y    = size_rd;
            sum_in   = add_sum;
            k_in     = '0;
            pend_in  = 1'b0;
            state_in = S_WALK;
         end
         S_WALK: begin
            // read vertex k while the previous read is checked and rewritten
            lbl_port.raddr = k_ff[kcm_pkg::ADDR_W-1:0];
            pend_in        = 1'b1;
            paddr_in       = k_ff[kcm_pkg::ADDR_W-1:0];
            k_in           = k_ff + kcm_pkg::V_W'(1);
            if (pend_ff && (lbl_rd == from_ff)) begin
               lbl_port.we    = 1'b1;
               lbl_port.waddr = paddr_ff;
               lbl_port.wdata = to_ff;
            end
            if (k_ff == need) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (pend_ff && (lbl_rd == from_ff)) begin
               lbl_port.we    = 1'b1;
               lbl_port.waddr = paddr_ff;
               lbl_port.wdata = to_ff;
            end
            pend_in  = 1'b0;
            state_in = S_SZW1;
         end
         S_SZW1: begin
            size_port.we    = 1'b1;
            size_port.waddr = to_m1[kcm_pkg::ADDR_W-1:0];
            size_port.wdata = sum_ff;
            state_in        = S_SZW2;
         end
         S_SZW2: begin
            size_port.we    = 1'b1;
            size_port.waddr = from_m1[kcm_pkg::ADDR_W-1:0];
            count_in        = count_inc;
            rsp_in          = make_rsp(req_ff, 1'b1, 1'b0, count_inc, need);
            rsp_valid_in    = 1'b1;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase

      if (clear_req) begin
         state_in = S_CLEAR;
         clr_in   = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      la_ff    <= la_in;
      lb_ff    <= lb_in;
      sa_ff    <= sa_in;
      from_ff  <= from_in;
      to_ff    <= to_in;
      sum_ff   <= sum_in;
      k_ff     <= k_in;
      paddr_ff <= paddr_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (k_ff < vertex_count))
      else $error("label walk ran past vertex_count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, count_ff} < vertex_count))
      else $error("tree edge count reached vertex_count");

   a_acc_no_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.accepted && rsp_ff.range_error))
      else $error("accepted edge flagged out of range");

   a_merge_done: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SZW2) && !clear_req) |=> (rsp_valid_ff && rsp_ff.accepted))
      else $error("merge finished without an accepted result");

endmodule
